### rtl/quoted_field_splitter_top_defines.svh
// Assertion macros for the quoted field splitter.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef QUOTED_FIELD_SPLITTER_TOP_DEFINES_SVH
`define QUOTED_FIELD_SPLITTER_TOP_DEFINES_SVH

// Check a consequence in the same cycle.
`define QFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle.
`define QFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qfs_pkg.sv
// Shared types and constants for the quoted field splitter.
// No dependencies; used by qfs_front, qfs_back and the top level.
`default_nettype none

package qfs_pkg;

    localparam logic       CFG_SEPARATOR = 1'b0;
    localparam logic       CFG_QUOTE     = 1'b1;
    localparam logic [15:0] SEP_RESET    = 16'd59;
    localparam logic [15:0] QUOTE_RESET  = 16'd34;

    typedef struct packed {
        logic [15:0] char_val;
        logic        is_end;
        logic        is_sep;
        logic        is_quote;
    } t_token;

    typedef struct packed {
        logic [15:0] char_out;
        logic        char_valid;
        logic [11:0] field_index;
        logic        field_end;
        logic        record_end;
        logic [12:0] field_count;
    } t_result;

endpackage

`default_nettype wire

### rtl/qfs_fifo.sv
// Small register-based FIFO with registered storage and first-word-fall-through output.
// Generic; no package dependencies.
`default_nettype none

module qfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/qfs_front.sv
// Front end: holds separator and quote registers, classifies each input character.
// Depends on qfs_pkg for the token type and register indexes.
`default_nettype none

module qfs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_tok_full,
    input  wire logic [15:0]   i_char_in,
    input  wire logic          i_is_end,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_tok_push,
    output qfs_pkg::t_token    o_tok
);

    logic [15:0] r_sep;
    logic [15:0] r_quote;

    assign o_cfg_ready = 1'b1;
    assign o_tok_push  = i_push && !i_tok_full;

    always_comb begin
        o_tok.char_val = i_char_in;
        o_tok.is_end   = i_is_end;
        o_tok.is_sep   = (i_char_in == r_sep);
        o_tok.is_quote = (i_char_in == r_quote);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= qfs_pkg::SEP_RESET;
            r_quote <= qfs_pkg::QUOTE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qfs_pkg::CFG_SEPARATOR: r_sep   <= i_cfg_data;
                qfs_pkg::CFG_QUOTE:     r_quote <= i_cfg_data;
                default:                r_sep   <= r_sep;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/qfs_back.sv
// Back end: quote/field state machine that turns classified tokens into results.
// Depends on qfs_pkg types and the assertion macros header.
`default_nettype none
`include "quoted_field_splitter_top_defines.svh"

module qfs_back #(
    parameter int MAX_FIELDS = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire qfs_pkg::t_token i_tok,
    input  wire logic          i_tok_empty,
    output logic               o_tok_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output qfs_pkg::t_result   o_res
);

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PLAIN   = 2'd1;
    localparam logic [1:0] MODE_QUOTED  = 2'd2;
    localparam logic [1:0] MODE_PENDING = 2'd3;

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);
    localparam int SUM_W = (CNT_W > 13) ? CNT_W : 13;

    logic [1:0]       r_mode;
    logic [1:0]       n_mode;
    logic [CNT_W-1:0] r_fields;
    logic [CNT_W-1:0] n_fields;
    logic             r_nonempty;
    logic             n_nonempty;
    logic             go;
    logic             emit;
    logic [SUM_W-1:0] fields_wide;
    logic [SUM_W-1:0] count_wide;
    logic             state_idle;
    logic             open_quote;
    logic             char_push;
    logic             res_marks_end;

    assign go          = !i_tok_empty && !i_res_full;
    assign o_tok_pop   = go;
    assign o_res_push  = go && emit;
    assign fields_wide = SUM_W'(r_fields);
    assign count_wide  = fields_wide + 1'b1;

    always_comb begin
        n_mode            = r_mode;
        n_fields          = r_fields;
        n_nonempty        = r_nonempty;
        emit              = 1'b0;
        o_res.char_out    = '0;
        o_res.char_valid  = 1'b0;
        o_res.field_index = fields_wide[11:0];
        o_res.field_end   = 1'b0;
        o_res.record_end  = 1'b0;
        o_res.field_count = '0;
        if (i_tok.is_end) begin
            emit             = 1'b1;
            o_res.record_end = 1'b1;
            if (r_nonempty) begin
                o_res.field_end   = 1'b1;
                o_res.field_count = count_wide[12:0];
            end
            n_mode     = MODE_START;
            n_fields   = '0;
            n_nonempty = 1'b0;
        end else begin
            n_nonempty = 1'b1;
            if ((r_mode == MODE_START) && i_tok.is_quote) begin
                n_mode = MODE_QUOTED;
            end else if (r_mode == MODE_QUOTED) begin
                if (i_tok.is_quote) begin
                    n_mode = MODE_PENDING;
                end else begin
                    emit             = 1'b1;
                    o_res.char_out   = i_tok.char_val;
                    o_res.char_valid = 1'b1;
                end
            end else if ((r_mode == MODE_PENDING) && i_tok.is_quote) begin
                n_mode           = MODE_QUOTED;
                emit             = 1'b1;
                o_res.char_out   = i_tok.char_val;
                o_res.char_valid = 1'b1;
            end else if (i_tok.is_sep) begin
                emit            = 1'b1;
                o_res.field_end = 1'b1;
                n_mode          = MODE_START;
                if (r_fields < CNT_W'(MAX_FIELDS - 1)) begin
                    n_fields = r_fields + 1'b1;
                end
            end else begin
                emit             = 1'b1;
                n_mode           = MODE_PLAIN;
                o_res.char_out   = i_tok.char_val;
                o_res.char_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_START;
            r_fields   <= '0;
            r_nonempty <= 1'b0;
        end else if (go) begin
            r_mode     <= n_mode;
            r_fields   <= n_fields;
            r_nonempty <= n_nonempty;
        end
    end

    assign state_idle    = (r_mode == MODE_START) && (r_fields == '0) && !r_nonempty;
    assign open_quote    = go && !i_tok.is_end && (r_mode == MODE_START) && i_tok.is_quote;
    assign char_push     = o_res_push && o_res.char_valid;
    assign res_marks_end = o_res.field_end || o_res.record_end;

    `QFS_ASSERT_NEXT(a_record_clears, go && i_tok.is_end, state_idle, "state kept after end")
    `QFS_ASSERT_NOW(a_fields_sat, 1'b1, r_fields <= CNT_W'(MAX_FIELDS - 1), "fields past limit")
    `QFS_ASSERT_NOW(a_open_quote_silent, open_quote, !o_res_push, "opening quote gave a result")
    `QFS_ASSERT_NOW(a_char_exclusive, char_push, !res_marks_end, "char result marks end")

endmodule

`default_nettype wire

### rtl/quoted_field_splitter_top.sv
// Quoted field splitter: qfs_front classifies each accepted character into the token queue;
// qfs_back turns tokens into results in the result queue, whose head drives the ports.
// Throughput one character per cycle unless the token queue is empty or result queue full.
// Token and result queues are two entries each; both sides stall independently.
// Reset (synchronous, active low) empties both queues, returns parse state to field start,
// and restores separator 59 and quote 34.
`default_nettype none

module quoted_field_splitter_top #(
    parameter int MAX_FIELDS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_char_in,
    input  wire logic        i_is_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_char_out,
    output logic             o_char_valid,
    output logic [11:0]      o_field_index,
    output logic             o_field_end,
    output logic             o_record_end,
    output logic [12:0]      o_field_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int TOK_W = $bits(qfs_pkg::t_token);
    localparam int RES_W = $bits(qfs_pkg::t_result);

    qfs_pkg::t_token  front_tok;
    qfs_pkg::t_token  back_tok;
    qfs_pkg::t_result back_res;
    qfs_pkg::t_result out_res;
    logic             tok_push;
    logic             tok_full;
    logic             tok_pop;
    logic             tok_empty;
    logic             res_push;
    logic             res_full;

    assign full = tok_full;

    qfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_tok_full  (tok_full),
        .i_char_in   (i_char_in),
        .i_is_end    (i_is_end),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_tok_push  (tok_push),
        .o_tok       (front_tok)
    );

    qfs_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (front_tok),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_empty (tok_empty),
        .o_data  (back_tok)
    );

    qfs_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (back_tok),
        .i_tok_empty (tok_empty),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    qfs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_char_out    = out_res.char_out;
    assign o_char_valid  = out_res.char_valid;
    assign o_field_index = out_res.field_index;
    assign o_field_end   = out_res.field_end;
    assign o_record_end  = out_res.record_end;
    assign o_field_count = out_res.field_count;

endmodule

`default_nettype wire
